// ===== src/pdh_pkg.sv =====
// ----------------------------------------------------------------------------
// pdh_pkg: shared types and constants
// Operation codes, widths and defaults for the pair distance histogram.
// ----------------------------------------------------------------------------
package pdh_pkg;

	localparam int MaxAtomsDefault = 1024;
	localparam int NumBinsDefault  = 64;

	localparam int CoordW = 20;
	localparam int TypeW  = 6;
	localparam int DistW  = 20;
	localparam int CountW = 32;
	localparam int D2W    = 43;  // three 41-bit squares summed
	localparam int SqrtW  = 22;  // floor(sqrt(d2)) fits in 22 bits

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_COMPUTE = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_SET1  = 3'd0,
		REG_SET2  = 3'd1,
		REG_LEFT  = 3'd2,
		REG_RIGHT = 3'd3,
		REG_WIDTH = 3'd4
	} reg_idx_t;

	// Kept pair handed from the distance pipe to the binning unit.
	typedef struct packed {
		logic             valid;
		logic [D2W-1:0]   d2;
	} pair_t;

	// Request from binner to histogram memory.
	typedef struct packed {
		logic        valid;
		logic [5:0]  bin;
	} bin_req_t;

endpackage

// ===== src/pdh_isqrt.sv =====
// ----------------------------------------------------------------------------
// pdh_isqrt: iterative integer square root and bin division
// One root bit per cycle, then a restoring divide by bin width, one quotient
// bit per cycle. Emits a kept pair's bin if root >= left and bin < 64.
// ----------------------------------------------------------------------------
module pdh_isqrt
	import pdh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  pair_t              pair,
	input  logic [DistW-1:0]   left_dist,
	input  logic [DistW-1:0]   bin_width,
	output logic               busy,
	output bin_req_t           req
);

	typedef enum logic [1:0] {S_IDLE, S_ROOT, S_DIV, S_DONE} st_t;

	localparam int RootSteps = (D2W + 1) / 2;  // 22

	st_t               st_q;
	logic [D2W+1:0]    rem_q;      // radicand / remainder
	logic [SqrtW-1:0]  root_q;
	logic [4:0]        cnt_q;
	logic [SqrtW-1:0]  num_q;
	logic [DistW:0]    drem_q;
	logic [DistW-1:0]  wid;

	logic [D2W+1:0]    trial;
	logic [D2W+1:0]    top2;
	logic [DistW:0]    dshift;

	assign wid = (bin_width == '0) ? DistW'(1) : bin_width;

	// one root digit: compare remainder top against 4*root+1
	always_comb begin
		top2  = rem_q >> (2 * cnt_q);
		trial = (D2W+2)'({root_q, 2'b01});
		dshift = {drem_q[DistW-1:0], num_q[cnt_q]};
	end

	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			req.valid <= 1'b0;
			req.bin   <= '0;
			cnt_q     <= '0;
			rem_q     <= '0;
			root_q    <= '0;
			num_q     <= '0;
			drem_q    <= '0;
		end else begin
			req.valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (pair.valid) begin
						rem_q  <= {1'b0, 1'b0, pair.d2};
						root_q <= '0;
						cnt_q  <= 5'(RootSteps - 1);
						st_q   <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (top2 >= trial) begin
						rem_q  <= rem_q - (trial << (2 * cnt_q));
						root_q <= {root_q[SqrtW-2:0], 1'b1};
					end else begin
						root_q <= {root_q[SqrtW-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						st_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_DIV: begin
					// set up divide: numerator = root - left
					num_q  <= root_q - SqrtW'(left_dist);
					drem_q <= '0;
					cnt_q  <= 5'(SqrtW - 1);
					st_q   <= (root_q < SqrtW'(left_dist)) ? S_IDLE : S_DONE;
				end
				S_DONE: begin
					// restoring division, MSB first; quotient builds in num_q
					if (dshift >= {1'b0, wid}) begin
						drem_q <= dshift - {1'b0, wid};
						num_q[cnt_q] <= 1'b1;
					end else begin
						drem_q <= dshift;
						num_q[cnt_q] <= 1'b0;
					end
					if (cnt_q == '0) begin
						st_q <= S_IDLE;
						// upper quotient bits are final; bit 0 comes from this step
						if (num_q[SqrtW-1:6] == '0) begin
							req.valid <= 1'b1;
							req.bin   <= {num_q[5:1], dshift >= {1'b0, wid}};
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/pdh_hist.sv =====
// ----------------------------------------------------------------------------
// pdh_hist: histogram memory with read-modify-write
// Bin counts in a synchronous memory; one saturating increment per in-range
// request, emission sweep reads bins in order. Clear sweep zeroes all bins.
// ----------------------------------------------------------------------------
module pdh_hist
	import pdh_pkg::*;
#(
	parameter int NUM_BINS = NumBinsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bin_req_t           req,
	input  logic               clear,
	input  logic               emit,
	output logic               busy,
	output logic               out_valid,
	output logic [5:0]         out_index,
	output logic [CountW-1:0]  out_count,
	output logic               out_last
);

	localparam int BW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

	typedef enum logic [1:0] {H_IDLE, H_CLEAR, H_EMIT, H_EMIT_END} hst_t;

	logic [CountW-1:0] mem [NUM_BINS];
	logic [CountW-1:0] rd_s1;
	hst_t              st_q;
	logic [BW-1:0]     sweep_q;
	logic              inc_s1;
	logic [BW-1:0]     inc_bin_s1;
	logic              emit_s1;
	logic [BW-1:0]     emit_bin_s1;
	logic              emit_last_s1;
	logic              in_range;
	logic [BW-1:0]     rd_addr;
	logic [CountW-1:0] cur;

	assign in_range = ({26'd0, req.bin} < 32'(NUM_BINS));
	assign rd_addr  = (st_q == H_EMIT) ? sweep_q : BW'(req.bin);
	assign busy     = (st_q != H_IDLE) || inc_s1;

	// requests are spaced by the root and divide steps of each kept pair, so the
	// read data is always current when the write back happens
	assign cur = rd_s1;

	// memory port
	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (st_q == H_CLEAR) begin
			mem[sweep_q] <= '0;
		end else if (inc_s1 && cur != '1) begin
			mem[inc_bin_s1] <= cur + CountW'(1);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= H_CLEAR;
			sweep_q    <= '0;
			inc_s1     <= 1'b0;
			inc_bin_s1 <= '0;
			emit_s1    <= 1'b0;
			emit_bin_s1 <= '0;
			emit_last_s1 <= 1'b0;
			out_valid  <= 1'b0;
			out_index  <= '0;
			out_count  <= '0;
			out_last   <= 1'b0;
		end else begin
			inc_s1     <= req.valid && in_range && st_q == H_IDLE;
			inc_bin_s1 <= BW'(req.bin);
			emit_s1    <= (st_q == H_EMIT);
			emit_bin_s1 <= sweep_q;
			emit_last_s1 <= (32'(sweep_q) == 32'(NUM_BINS - 1));
			out_valid  <= emit_s1;
			out_index  <= 6'(emit_bin_s1);
			out_count  <= rd_s1;
			out_last   <= emit_last_s1;
			case (st_q)
				H_IDLE: begin
					sweep_q <= '0;
					if (clear) st_q <= H_CLEAR;
					else if (emit) st_q <= H_EMIT;
				end
				H_CLEAR: begin
					if (32'(sweep_q) == 32'(NUM_BINS - 1)) st_q <= H_IDLE;
					else sweep_q <= sweep_q + BW'(1);
				end
				H_EMIT: begin
					if (32'(sweep_q) == 32'(NUM_BINS - 1)) st_q <= H_EMIT_END;
					else sweep_q <= sweep_q + BW'(1);
				end
				H_EMIT_END: begin
					if (!emit_s1) st_q <= H_IDLE;
				end
				default: st_q <= H_IDLE;
			endcase
		end
	end

endmodule

// ===== src/pair_distance_histogram_top.sv =====
// ----------------------------------------------------------------------------
// pair_distance_histogram_top: pair distance histogram
// Atom store, pair walker with squared distance pipe, root/divide unit and
// histogram memory.
// ----------------------------------------------------------------------------
// Usage: a request is taken when start is high and busy low. A load
// (operation 1) writes one atom unless the store is full; a clear (operation
// 0) resets the atom count and sweeps the NUM_BINS histogram entries, one per
// cycle. Compute (operation 2) first clears the histogram, then walks all
// ordered pairs from the atom memory, one pair per cycle unless stalled,
// through a five-stage distance pipe. Each kept pair holds the walk for the
// hand-off, 22 root steps, one setup step and 22 quotient steps; pairs
// rejected by type or range do not hold it. The sweep then emits NUM_BINS
// results on result_valid, one per cycle, the last with last_bin set.
// Results cannot be stalled. After reset the block clears the histogram
// memory with busy high.
// Configuration lies on the APB port at byte addresses 8*i, 64-bit data.
// ----------------------------------------------------------------------------
module pair_distance_histogram_top
	import pdh_pkg::*;
#(
	parameter int MAX_ATOMS = MaxAtomsDefault,
	parameter int NUM_BINS  = NumBinsDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [5:0]                paddr,
	input  logic [63:0]               pwdata,
	output logic [63:0]               prdata,
	output logic                      pready,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [TypeW-1:0]          type_id,
	input  logic signed [CoordW-1:0]  pos_x,
	input  logic signed [CoordW-1:0]  pos_y,
	input  logic signed [CoordW-1:0]  pos_z,
	output logic                      result_valid,
	output logic [5:0]                bin_index,
	output logic [CountW-1:0]         bin_count,
	output logic                      last_bin
);

	localparam int AW = $clog2(MAX_ATOMS);
	localparam int CW = AW + 1;
	localparam int EW = TypeW + 3 * CoordW;

	typedef enum logic [2:0] {T_IDLE, T_HCLR, T_WALK, T_DRAIN, T_EMIT} tst_t;

	// configuration registers
	logic [63:0]      set1_q, set2_q;
	logic [DistW-1:0] left_q, right_q, width_q;
	logic             wr;
	reg_idx_t         widx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign widx   = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set1_q  <= '0;
			set2_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
			width_q <= DistW'(256);
		end else if (wr) begin
			case (widx)
				REG_SET1:  set1_q  <= pwdata;
				REG_SET2:  set2_q  <= pwdata;
				REG_LEFT:  left_q  <= pwdata[DistW-1:0];
				REG_RIGHT: right_q <= pwdata[DistW-1:0];
				REG_WIDTH: width_q <= pwdata[DistW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_SET1:  prdata = set1_q;
			REG_SET2:  prdata = set2_q;
			REG_LEFT:  prdata = {44'd0, left_q};
			REG_RIGHT: prdata = {44'd0, right_q};
			REG_WIDTH: prdata = {44'd0, width_q};
			default:   prdata = '0;
		endcase
	end

	// atom memory: two read ports (i and j), one write port
	logic [EW-1:0] amem [MAX_ATOMS];
	logic [EW-1:0] ai_s1, aj_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q, j_q;
	tst_t          st_q;
	logic          accept;
	logic          walk_v;
	logic          hbusy, rbusy;
	logic          hclear, hemit;
	pair_t         pair;
	bin_req_t      breq;

	// distance pipe: s1 read, s2 differences, s3 squares, s4 sum, s5 checks
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [CoordW:0]   dx_s2, dy_s2, dz_s2;
	logic                     tok_s2;
	logic signed [2*CoordW+1:0] qx, qy, qz;
	logic [2*CoordW+1:0]      sx_s3, sy_s3, sz_s3;
	logic                     tok_s3;
	logic [D2W-1:0]           d2_s4, d2_s5;
	logic                     tok_s4;
	logic                     keep_s5;
	logic [2*DistW-1:0]       lo2_q, hi2_q;
	logic                     stall;

	assign accept = start && !busy;

	// read data holds with the pipe so it stays matched to v_s1
	always_ff @(posedge clk) begin
		if (accept && op_t'(operation) == OP_LOAD && count_q < CW'(MAX_ATOMS)) begin
			amem[count_q[AW-1:0]] <= {type_id, pos_x, pos_y, pos_z};
		end
		if (!stall) begin
			ai_s1 <= amem[i_q[AW-1:0]];
			aj_s1 <= amem[j_q[AW-1:0]];
		end
	end

	// pipe holds while root unit works on a kept pair
	assign stall = rbusy || pair.valid;

	always_ff @(posedge clk) begin
		lo2_q <= left_q * left_q;
		hi2_q <= right_q * right_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= walk_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// full-width signed squares of the differences
	assign qx = dx_s2 * dx_s2;
	assign qy = dy_s2 * dy_s2;
	assign qz = dz_s2 * dz_s2;

	always_ff @(posedge clk) begin
		if (!stall) begin
			dx_s2  <= (CoordW+1)'(signed'(ai_s1[3*CoordW-1 -: CoordW]))
				- (CoordW+1)'(signed'(aj_s1[3*CoordW-1 -: CoordW]));
			dy_s2  <= (CoordW+1)'(signed'(ai_s1[2*CoordW-1 -: CoordW]))
				- (CoordW+1)'(signed'(aj_s1[2*CoordW-1 -: CoordW]));
			dz_s2  <= (CoordW+1)'(signed'(ai_s1[CoordW-1:0]))
				- (CoordW+1)'(signed'(aj_s1[CoordW-1:0]));
			tok_s2 <= set1_q[ai_s1[EW-1 -: TypeW]] && set2_q[aj_s1[EW-1 -: TypeW]];
			sx_s3  <= unsigned'(qx);
			sy_s3  <= unsigned'(qy);
			sz_s3  <= unsigned'(qz);
			tok_s3 <= tok_s2;
			d2_s4  <= D2W'(sx_s3) + D2W'(sy_s3) + D2W'(sz_s3);
			tok_s4 <= tok_s3;
			d2_s5  <= d2_s4;
			keep_s5 <= tok_s4 && d2_s4 >= D2W'(lo2_q) && d2_s4 <= D2W'(hi2_q);
		end
	end

	// hand one kept pair to the root unit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair.valid <= 1'b0;
			pair.d2    <= '0;
		end else begin
			pair.valid <= !stall && v_s5 && keep_s5;
			pair.d2    <= d2_s5;
		end
	end

	pdh_isqrt u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair      (pair),
		.left_dist (left_q),
		.bin_width (width_q),
		.busy      (rbusy),
		.req       (breq)
	);

	pdh_hist #(.NUM_BINS(NUM_BINS)) u_hist (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (breq),
		.clear     (hclear),
		.emit      (hemit),
		.busy      (hbusy),
		.out_valid (result_valid),
		.out_index (bin_index),
		.out_count (bin_count),
		.out_last  (last_bin)
	);

	// sequencer: walks i over outer, j over inner
	assign walk_v = (st_q == T_WALK) && !stall && (count_q != '0);
	assign busy   = (st_q != T_IDLE) || hbusy;

	logic [3:0] drain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= T_IDLE;
			count_q <= '0;
			i_q     <= '0;
			j_q     <= '0;
			hclear  <= 1'b0;
			hemit   <= 1'b0;
			drain_q <= '0;
		end else begin
			hclear <= 1'b0;
			hemit  <= 1'b0;
			case (st_q)
				T_IDLE: begin
					if (accept) begin
						case (op_t'(operation))
							OP_CLEAR: begin
								count_q <= '0;
								hclear  <= 1'b1;
							end
							OP_LOAD: begin
								if (count_q < CW'(MAX_ATOMS)) count_q <= count_q + CW'(1);
							end
							OP_COMPUTE: begin
								hclear <= 1'b1;
								i_q    <= '0;
								j_q    <= '0;
								st_q   <= T_HCLR;
							end
							default: ;
						endcase
					end
				end
				T_HCLR: begin
					if (!hclear && !hbusy) st_q <= T_WALK;
				end
				T_WALK: begin
					if (count_q == '0) begin
						st_q <= T_DRAIN;
						drain_q <= '0;
					end else if (!stall) begin
						if (j_q == count_q - CW'(1)) begin
							j_q <= '0;
							if (i_q == count_q - CW'(1)) begin
								st_q    <= T_DRAIN;
								drain_q <= '0;
							end else begin
								i_q <= i_q + CW'(1);
							end
						end else begin
							j_q <= j_q + CW'(1);
						end
					end
				end
				T_DRAIN: begin
					if (!stall && !hbusy && !v_s1 && !v_s2 && !v_s3 && !v_s4 && !v_s5) begin
						drain_q <= drain_q + 4'd1;
						if (drain_q == 4'd3) begin
							hemit <= 1'b1;
							st_q  <= T_EMIT;
						end
					end else begin
						drain_q <= '0;
					end
				end
				T_EMIT: begin
					if (!hemit && !hbusy) st_q <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

endmodule

// ===== dv/pair_distance_histogram_top_tb.sv =====
// ----------------------------------------------------------------------------
// pair_distance_histogram_top_tb: self-checking bench for the histogram block
// Loads small atom sets under many register settings, issues compute
// requests and checks every emitted bin against an in-bench histogram model.
// ----------------------------------------------------------------------------
module pair_distance_histogram_top_tb;
	import pdh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AtomCap   = MaxAtomsDefault;
	localparam int BinCount  = NumBinsDefault;
	localparam int LoadItems = 460;
	localparam longint CycleLimit = 64'd30_000_000;

	typedef struct {
		op_t               op;
		logic [TypeW-1:0]  typ;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [CoordW-1:0] z;
	} atom_req_t;

	typedef struct {
		logic [5:0]        idx;
		logic [CountW-1:0] cnt;
		logic              last;
	} bin_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [5:0] paddr;
	logic [63:0] pwdata, prdata;
	logic pready;
	logic start, busy;
	logic [1:0] operation;
	logic [TypeW-1:0] type_id;
	logic signed [CoordW-1:0] pos_x, pos_y, pos_z;
	logic result_valid;
	logic [5:0] bin_index;
	logic [CountW-1:0] bin_count;
	logic last_bin;

	pair_distance_histogram_top dut (.*);

	// request queue, expected bins, model state
	atom_req_t req_q[$];
	bin_t      bin_expect_q[$];
	logic [63:0] m_set1, m_set2;
	longint unsigned m_left, m_right, m_width;
	logic [TypeW-1:0] m_types[AtomCap];
	int        m_x[AtomCap], m_y[AtomCap], m_z[AtomCap];
	int        m_count;
	int        errors, accepted, computes, bins_checked, gap_cnt;
	bit        no_gaps;
	longint    cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("[pair_distance_histogram_top] ERROR");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// histogram of all ordered pairs, queues one expected entry per bin
	task automatic predict_histogram();
		longint unsigned lo2, hi2, w, d2, s, b;
		longint dx, dy, dz;
		logic [CountW-1:0] hist[BinCount];
		bin_t e;
		lo2 = m_left * m_left;
		hi2 = m_right * m_right;
		w = (m_width == 0) ? 1 : m_width;
		foreach (hist[k]) hist[k] = '0;
		for (int i = 0; i < m_count; i++) begin
			if (!m_set1[m_types[i]]) continue;
			for (int j = 0; j < m_count; j++) begin
				if (!m_set2[m_types[j]]) continue;
				dx = longint'(m_x[i]) - m_x[j];
				dy = longint'(m_y[i]) - m_y[j];
				dz = longint'(m_z[i]) - m_z[j];
				d2 = dx * dx + dy * dy + dz * dz;
				if (d2 < lo2 || d2 > hi2) continue;
				s = int_sqrt(d2);
				if (s < m_left) continue;
				b = (s - m_left) / w;
				if (b >= BinCount) continue;
				if (hist[b] != '1) hist[b]++;
			end
		end
		for (int k = 0; k < BinCount; k++) begin
			e.idx = k[5:0];
			e.cnt = hist[k];
			e.last = (k == BinCount - 1);
			bin_expect_q.insert(bin_expect_q.size(), e);
		end
	endtask

	// driver: start held until accepted, random gaps between requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_cnt <= 0;
		end else if (!start || !busy) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				start <= 1'b0;
			end else if (req_q.size() > 0) begin
				atom_req_t r;
				int p;
				r = req_q.pop_front();
				operation <= r.op;
				type_id <= r.typ;
				pos_x <= r.x;
				pos_y <= r.y;
				pos_z <= r.z;
				start <= 1'b1;
				p = $urandom_range(0, 99);
				if (no_gaps || p < 60) gap_cnt <= 0;
				else if (p < 92) gap_cnt <= $urandom_range(1, 3);
				else gap_cnt <= $urandom_range(10, 40);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: update model on accepted request, check each bin
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			accepted++;
			case (op_t'(operation))
				OP_CLEAR: m_count = 0;
				OP_LOAD: begin
					if (m_count < AtomCap) begin
						m_types[m_count] = type_id;
						m_x[m_count] = pos_x;
						m_y[m_count] = pos_y;
						m_z[m_count] = pos_z;
						m_count++;
					end
				end
				OP_COMPUTE: begin
					computes++;
					predict_histogram();
				end
				default: ;
			endcase
		end
		if (arst_n && result_valid) begin
			bin_t e;
			if (bin_expect_q.size() == 0) begin
				errors++;
				$display("%t unexpected bin: idx %0d cnt %0d last %0b", $time,
					bin_index, bin_count, last_bin);
			end else begin
				e = bin_expect_q.pop_front();
				bins_checked++;
				if (bin_index !== e.idx || bin_count !== e.cnt || last_bin !== e.last) begin
					errors++;
					$display("%t bin mismatch: expected idx %0d cnt %0d last %0b,",
						$time, e.idx, e.cnt, e.last);
					$display("    actual idx %0d cnt %0d last %0b",
						bin_index, bin_count, last_bin);
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(idx) << 3;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_SET1:  m_set1 = val;
			REG_SET2:  m_set2 = val;
			REG_LEFT:  m_left = val[19:0];
			REG_RIGHT: m_right = val[19:0];
			REG_WIDTH: m_width = val[19:0];
			default: ;
		endcase
	endtask

	task automatic set_window(logic [63:0] s1, logic [63:0] s2,
		logic [19:0] lft, logic [19:0] rgt, logic [19:0] wid);
		reg_write(REG_SET1, s1);
		reg_write(REG_SET2, s2);
		reg_write(REG_LEFT, {44'd0, lft});
		reg_write(REG_RIGHT, {44'd0, rgt});
		reg_write(REG_WIDTH, {44'd0, wid});
	endtask

	// wait for all requests and bins, then for a clear sweep to finish
	task automatic drain();
		while (req_q.size() != 0 || start || bin_expect_q.size() != 0 || busy)
			@(posedge clk);
		repeat (2 * BinCount + 20) @(posedge clk);
	endtask

	task automatic push_req(op_t op, logic [5:0] t, logic [19:0] x, logic [19:0] y,
		logic [19:0] z);
		atom_req_t r;
		r.op = op;
		r.typ = t;
		r.x = x;
		r.y = y;
		r.z = z;
		req_q.insert(req_q.size(), r);
	endtask

	function automatic logic [19:0] rand_coord();
		return 20'($urandom_range(0, 20'hFFFFF));
	endfunction

	initial begin
		logic [19:0] cx, cy, cz, lft, rgt, wid;
		logic [63:0] s1, s2;
		int n, p, sent;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		operation = OP_NONE;
		type_id = '0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		errors = 0;
		accepted = 0;
		computes = 0;
		bins_checked = 0;
		cycles = 0;
		no_gaps = 0;
		m_set1 = '0;
		m_set2 = '0;
		m_left = 0;
		m_right = 0;
		m_width = 256;
		m_count = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// directed: extreme coordinates and types, unused op, wide window
		set_window('1, '1, 20'd0, 20'hFFFFF, 20'd256);
		push_req(OP_CLEAR, 6'd0, '0, '0, '0);
		push_req(OP_LOAD, 6'd0, 20'h80000, 20'h80000, 20'h80000);
		push_req(OP_LOAD, 6'd63, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
		push_req(OP_LOAD, 6'd21, 20'h00000, 20'hFFFFF, 20'h00100);
		push_req(OP_LOAD, 6'd42, 20'h00000, 20'hFFFFF, 20'h00100);
		push_req(OP_NONE, 6'd63, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();
		// widest bins at the far bound
		set_window(64'h8000_0000_0000_0001, '1, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();
		// reversed bounds, then zero width, then far bins with width one
		set_window('1, '1, 20'd500, 20'd100, 20'd16);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();
		set_window('1, '1, 20'd0, 20'd400, 20'd0);
		push_req(OP_LOAD, 6'd5, 20'h00010, 20'h00000, 20'h00000);
		push_req(OP_LOAD, 6'd5, 20'h00000, 20'h00020, 20'h00000);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();
		set_window(64'h20, 64'h20, 20'd0, 20'hFFFFF, 20'd1);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		push_req(OP_CLEAR, 6'd0, '0, '0, '0);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();

		// random phases: clustered atoms, random windows and masks
		sent = 0;
		while (sent < LoadItems) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			s1 = {$urandom, $urandom};
			s2 = {$urandom, $urandom};
			p = $urandom_range(0, 9);
			if (p == 0) s1 = '1;
			if (p == 1) s2 = '0;
			lft = (p < 7) ? 20'($urandom_range(0, 600)) : rand_coord();
			rgt = (p == 8) ? 20'hFFFFF : 20'(lft + $urandom_range(0, 2500));
			if (p == 9) rgt = 20'($urandom_range(0, 600));
			p = $urandom_range(0, 9);
			wid = (p == 0) ? 20'd0 : (p == 1) ? 20'd1 : (p == 2) ? 20'hFFFFF
				: 20'($urandom_range(2, 200));
			set_window(s1, s2, lft, rgt, wid);
			if ($urandom_range(0, 3) != 0) push_req(OP_CLEAR, 6'd0, '0, '0, '0);
			if (m_count > 20) push_req(OP_CLEAR, 6'd0, '0, '0, '0);
			cx = rand_coord();
			cy = rand_coord();
			cz = rand_coord();
			n = $urandom_range(2, 12);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					push_req(OP_LOAD, 6'($urandom), rand_coord(), rand_coord(),
						rand_coord());
				else
					push_req(OP_LOAD, 6'($urandom_range(0, 7) * 9),
						20'(cx + $urandom_range(0, 1200)),
						20'(cy - $urandom_range(0, 1200)),
						20'(cz + $urandom_range(0, 800)));
				if ($urandom_range(0, 15) == 0)
					push_req(OP_NONE, 6'($urandom), rand_coord(), rand_coord(),
						rand_coord());
			end
			sent += n;
			push_req(OP_COMPUTE, 6'($urandom), rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		// store full: loads past capacity must be ignored
		no_gaps = 1;
		set_window(64'h4, 64'h4, 20'd0, 20'hFFFFF, 20'd64);
		push_req(OP_CLEAR, 6'd0, '0, '0, '0);
		for (int k = 0; k < AtomCap - 2; k++)
			push_req(OP_LOAD, 6'd1, rand_coord(), rand_coord(), rand_coord());
		push_req(OP_LOAD, 6'd2, 20'd0, 20'd0, 20'd0);
		push_req(OP_LOAD, 6'd2, 20'd300, 20'd0, 20'd0);
		for (int k = 0; k < 3; k++)
			push_req(OP_LOAD, 6'd2, 20'(k * 100), 20'd50, 20'd0);
		push_req(OP_COMPUTE, 6'd0, '0, '0, '0);
		drain();

		$display("covered %0d requests, %0d compute runs, %0d bins checked",
			accepted, computes, bins_checked);
		if (errors == 0 && bin_expect_q.size() == 0) begin
			$display("[pair_distance_histogram_top] OK");
		end else begin
			$display("%0d errors, %0d bins never seen", errors, bin_expect_q.size());
			$display("[pair_distance_histogram_top] ERROR");
		end
		$finish;
	end

endmodule
